>>> rtl/kea_pkg.sv
// Shared types and constants of the edge acceptor: word layouts, widths,
// operation and register codes. No dependencies.
package kea_pkg;

    localparam int NODE_W  = 10;
    localparam int COUNT_W = 11;
    localparam int COST_W  = 26;
    localparam int EDGE_W  = 16;
    localparam int USED_W  = 10;

    localparam logic [COST_W-1:0]  COST_MAX       = 26'h3FF_FFFF;
    localparam logic [COUNT_W-1:0] MIN_NODES      = 11'd2;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    localparam logic CFG_NODE_COUNT  = 1'b0;
    localparam logic CFG_TARGET_COST = 1'b1;

    typedef struct packed {
        logic              op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [EDGE_W-1:0] edge_cost;
        logic              final_edge;
    } edge_word_t;

    typedef struct packed {
        logic              taken;
        logic [COST_W-1:0] total_cost;
        logic [USED_W-1:0] used_edges;
        logic              tree_complete;
        logic              cost_matches;
        logic              last_flag;
    } result_word_t;

    typedef struct packed {
        logic              valid;
        logic              taken;
        logic [COST_W-1:0] total_cost;
        logic [USED_W-1:0] used_edges;
        logic              last_flag;
    } seq_result_t;

endpackage

>>> rtl/kea_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/kea_forest_seq.sv
// Disjoint-set forest sequencer: root walks, path compression, union by size,
// clearing sweep and running totals. Depends on kea_pkg and kea_ram.
module kea_forest_seq #(
    parameter int MAX_NODES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         edge_valid,
    output logic                         edge_stall,
    input  kea_pkg::edge_word_t          edge_word,
    input  logic [kea_pkg::COUNT_W-1:0]  node_limit,
    input  logic                         res_free,
    output kea_pkg::seq_result_t         res
);
    import kea_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int SW = AW + 1;
    localparam int EW = AW + SW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_COMP,
        S_JOIN,
        S_UNITE,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    edge_word_t        item_reg, item_next;
    logic              side_reg, side_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     root_a_reg, root_a_next;
    logic [AW-1:0]     root_b_reg, root_b_next;
    logic [SW-1:0]     size_a_reg, size_a_next;
    logic [SW-1:0]     size_b_reg, size_b_next;
    logic              taken_reg, taken_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic              clr_pend_reg, clr_pend_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [EW-1:0]     wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [EW-1:0]     rdata;

    logic [AW-1:0]     rd_parent;
    logic [SW-1:0]     rd_size;
    logic [AW-1:0]     a_addr;
    logic [AW-1:0]     b_addr;
    logic [AW-1:0]     start_addr;
    logic [AW-1:0]     root_cur;
    logic              a_gt_b;
    logic [AW-1:0]     winner;
    logic [AW-1:0]     loser;
    logic [SW-1:0]     loser_size;
    logic [COST_W:0]   cost_sum;
    logic [COST_W-1:0] cost_sat;
    logic              edge_ok;

    kea_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_forest_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_parent  = rdata[EW-1:SW];
    assign rd_size    = rdata[SW-1:0];
    assign a_addr     = AW'(item_reg.node_a);
    assign b_addr     = AW'(item_reg.node_b);
    assign start_addr = side_reg ? b_addr : a_addr;
    assign root_cur   = side_reg ? root_b_reg : root_a_reg;
    assign a_gt_b     = size_a_reg > size_b_reg;
    assign winner     = a_gt_b ? root_a_reg : root_b_reg;
    assign loser      = a_gt_b ? root_b_reg : root_a_reg;
    assign loser_size = a_gt_b ? size_b_reg : size_a_reg;
    assign cost_sum   = {1'b0, cost_reg} + (COST_W + 1)'(item_reg.edge_cost);
    assign cost_sat   = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

    assign edge_ok = ({1'b0, edge_word.node_a} < node_limit)
                  && ({1'b0, edge_word.node_b} < node_limit)
                  && (32'(edge_word.node_a) < MAX_NODES)
                  && (32'(edge_word.node_b) < MAX_NODES)
                  && ({1'b0, used_reg} < (node_limit - COUNT_W'(1)));

    assign edge_stall     = (state_reg != S_IDLE);
    assign res.valid      = (state_reg == S_DONE) && res_free;
    assign res.taken      = taken_reg;
    assign res.total_cost = cost_reg;
    assign res.used_edges = used_reg;
    assign res.last_flag  = item_reg.final_edge;

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        side_next     = side_reg;
        cur_next      = cur_reg;
        root_a_next   = root_a_reg;
        root_b_next   = root_b_reg;
        size_a_next   = size_a_reg;
        size_b_next   = size_b_reg;
        taken_next    = taken_reg;
        cost_next     = cost_reg;
        used_next     = used_reg;
        clr_pend_next = clr_pend_reg;
        clr_cnt_next  = clr_cnt_reg;
        we            = 1'b0;
        waddr         = cur_reg;
        wdata         = '0;
        re            = 1'b0;
        raddr         = cur_reg;

        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                wdata = {clr_cnt_reg, SW'(1)};
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (edge_valid)
                begin
                    item_next  = edge_word;
                    taken_next = 1'b0;
                    if (edge_word.op == OP_CLEAR)
                    begin
                        cost_next     = '0;
                        used_next     = '0;
                        clr_pend_next = 1'b1;
                        state_next    = S_DONE;
                    end
                    else if (edge_ok)
                    begin
                        re         = 1'b1;
                        raddr      = AW'(edge_word.node_a);
                        cur_next   = AW'(edge_word.node_a);
                        side_next  = 1'b0;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                if (rd_parent == cur_reg)
                begin
                    if (side_reg)
                    begin
                        root_b_next = cur_reg;
                        size_b_next = rd_size;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        size_a_next = rd_size;
                    end
                    if (cur_reg != start_addr)
                    begin
                        // second pass over the path to point it at the root
                        re         = 1'b1;
                        raddr      = start_addr;
                        cur_next   = start_addr;
                        state_next = S_COMP;
                    end
                    else if (!side_reg)
                    begin
                        re         = 1'b1;
                        raddr      = b_addr;
                        cur_next   = b_addr;
                        side_next  = 1'b1;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_JOIN;
                    end
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = rd_parent;
                    cur_next = rd_parent;
                end
            end
            S_COMP:
            begin
                if (cur_reg == root_cur)
                begin
                    if (!side_reg)
                    begin
                        re         = 1'b1;
                        raddr      = b_addr;
                        cur_next   = b_addr;
                        side_next  = 1'b1;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_JOIN;
                    end
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = cur_reg;
                    wdata    = {root_cur, rd_size};
                    re       = 1'b1;
                    raddr    = rd_parent;
                    cur_next = rd_parent;
                end
            end
            S_JOIN:
            begin
                if (root_a_reg == root_b_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = loser;
                    wdata      = {winner, loser_size};
                    state_next = S_UNITE;
                end
            end
            S_UNITE:
            begin
                we         = 1'b1;
                waddr      = winner;
                wdata      = {winner, size_a_reg + size_b_reg};
                cost_next  = cost_sat;
                used_next  = used_reg + USED_W'(1);
                taken_next = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    clr_pend_next = 1'b0;
                    state_next    = clr_pend_reg ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            item_reg     <= '0;
            side_reg     <= 1'b0;
            cur_reg      <= '0;
            root_a_reg   <= '0;
            root_b_reg   <= '0;
            size_a_reg   <= '0;
            size_b_reg   <= '0;
            taken_reg    <= 1'b0;
            cost_reg     <= '0;
            used_reg     <= '0;
            clr_pend_reg <= 1'b0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            item_reg     <= item_next;
            side_reg     <= side_next;
            cur_reg      <= cur_next;
            root_a_reg   <= root_a_next;
            root_b_reg   <= root_b_next;
            size_a_reg   <= size_a_next;
            size_b_reg   <= size_b_next;
            taken_reg    <= taken_next;
            cost_reg     <= cost_next;
            used_reg     <= used_next;
            clr_pend_reg <= clr_pend_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

endmodule

>>> rtl/kruskal_edge_acceptor_core.sv
// Kruskal edge acceptor top level: configuration registers, result register
// and the forest sequencer. Depends on kea_pkg and kea_forest_seq.
//
// Takes edges in ascending cost order, one word at a time, and keeps a
// union-find forest (union by size, path compression) in one RAM of
// MAX_NODES entries, each holding a parent link and a set size. A taken edge
// costs a walk from node_a to its root and, when node_a is not a root, a
// second compression pass that points each link on the path at the root;
// node_b likewise. A taken edge then links one root under the other and
// writes the new set size. Each link is one RAM
// read, so the single read port sets the rate. Out-of-range or late edges
// skip the RAM. A stalled result adds its wait to the word behind it.
// A clear word returns its result and then sweeps the RAM; the same sweep
// runs after reset. No edge is taken while a sweep runs; configuration
// writes are always taken. A new word is taken while an earlier result
// still waits in the output register.
module kruskal_edge_acceptor_core #(
    parameter int MAX_NODES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         edge_valid,
    output logic                         edge_stall,
    input  kea_pkg::edge_word_t          edge_word,
    output logic                         result_valid,
    input  logic                         result_stall,
    output kea_pkg::result_word_t        result_word,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [kea_pkg::COST_W-1:0]   cfg_data
);
    import kea_pkg::*;

    logic [COUNT_W-1:0] node_count_reg;
    logic [COST_W-1:0]  target_cost_reg;
    logic [COUNT_W-1:0] node_limit;
    logic               res_free;
    seq_result_t        res;
    logic               complete;
    logic               result_valid_reg;
    result_word_t       result_word_reg;

    assign cfg_ready  = 1'b1;
    assign node_limit = (node_count_reg < MIN_NODES) ? MIN_NODES : node_count_reg;
    assign res_free   = !result_valid_reg || !result_stall;
    assign complete   = ({1'b0, res.used_edges} == (node_limit - COUNT_W'(1)));

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    kea_forest_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .edge_stall (edge_stall),
        .edge_word  (edge_word),
        .node_limit (node_limit),
        .res_free   (res_free),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= MIN_NODES;
            target_cost_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NODE_COUNT:  node_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_TARGET_COST: target_cost_reg <= cfg_data;
                default:         node_count_reg  <= node_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_word_reg  <= '0;
        end
        else if (res.valid)
        begin
            result_valid_reg              <= 1'b1;
            result_word_reg.taken         <= res.taken;
            result_word_reg.total_cost    <= res.total_cost;
            result_word_reg.used_edges    <= res.used_edges;
            result_word_reg.tree_complete <= complete;
            result_word_reg.cost_matches  <= complete && (res.total_cost == target_cost_reg);
            result_word_reg.last_flag     <= res.last_flag;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

endmodule

>>> sim/kruskal_edge_acceptor_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for kruskal_edge_acceptor_core: a union-find model predicts
// every result word; directed, random-graph and backpressure tests run in turn.
// Depends on kea_pkg and the core RTL only.
module kruskal_edge_acceptor_core_test;
    import kea_pkg::*;

    localparam int MAX_NODES     = 1024;
    localparam int RANDOM_WORDS  = 940;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 8000;
    localparam int REPORT_LIMIT  = 10;

    logic                clk;
    logic                rst_n;
    logic                edge_valid;
    logic                edge_stall;
    edge_word_t          edge_word;
    logic                result_valid;
    logic                result_stall;
    result_word_t        result_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [COST_W-1:0]   cfg_data;

    // forest model
    logic [NODE_W-1:0]   link_of [MAX_NODES];
    logic [COUNT_W-1:0]  size_of [MAX_NODES];
    int unsigned         tree_cost;
    int unsigned         tree_edges;
    logic [COUNT_W-1:0]  cfg_nodes;
    logic [COST_W-1:0]   cfg_target;

    result_word_t        expected_results [$];

    bit                  sender_gaps;
    bit                  receiver_stalls;
    int                  hold_cycles;
    int unsigned         words_sent;
    int unsigned         clears_sent;
    int unsigned         results_seen;
    int unsigned         taken_seen;
    int unsigned         matches_seen;
    int unsigned         mismatches;

    kruskal_edge_acceptor_core #(
        .MAX_NODES(MAX_NODES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .edge_valid(edge_valid),
        .edge_stall(edge_stall),
        .edge_word(edge_word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_word(result_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_forest();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            link_of[i] = NODE_W'(i);
            size_of[i] = COUNT_W'(1);
        end
        tree_cost  = 0;
        tree_edges = 0;
    endfunction

    function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] nxt;
        int steps;
        r = v;
        steps = 0;
        while (link_of[r] != r && steps < MAX_NODES)
        begin
            r = link_of[r];
            steps++;
        end
        steps = 0;
        while (v != r && steps < MAX_NODES)
        begin
            nxt = link_of[v];
            link_of[v] = r;
            v = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic result_word_t predict_result(input edge_word_t w);
        result_word_t r;
        int unsigned n;
        logic [NODE_W-1:0] ra;
        logic [NODE_W-1:0] rb;
        r = '0;
        n = (cfg_nodes < MIN_NODES) ? MIN_NODES : cfg_nodes;
        if (w.op == OP_CLEAR)
        begin
            clear_forest();
        end
        else if (w.node_a < n && w.node_b < n && tree_edges < n - 1)
        begin
            ra = find_root(w.node_a);
            rb = find_root(w.node_b);
            if (ra != rb)
            begin
                if (size_of[ra] > size_of[rb])
                begin
                    link_of[rb] = ra;
                    size_of[ra] = size_of[ra] + size_of[rb];
                end
                else
                begin
                    link_of[ra] = rb;
                    size_of[rb] = size_of[rb] + size_of[ra];
                end
                tree_cost = (tree_cost + w.edge_cost > COST_MAX) ? COST_MAX
                                                                 : tree_cost + w.edge_cost;
                tree_edges++;
                r.taken = 1'b1;
            end
        end
        r.total_cost    = COST_W'(tree_cost);
        r.used_edges    = USED_W'(tree_edges);
        r.tree_complete = (tree_edges == n - 1);
        r.cost_matches  = r.tree_complete && (tree_cost == cfg_target);
        r.last_flag     = w.final_edge;
        return r;
    endfunction

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic edge_word_t edge_of(input int unsigned a, b, cost, input bit fin);
        edge_word_t w;
        w.op         = OP_EDGE;
        w.node_a     = NODE_W'(a);
        w.node_b     = NODE_W'(b);
        w.edge_cost  = EDGE_W'(cost);
        w.final_edge = fin;
        return w;
    endfunction

    function automatic edge_word_t clear_word();
        edge_word_t w;
        logic [$bits(edge_word_t)-1:0] raw;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        raw = rnd[$bits(edge_word_t)-1:0];
        w = raw;
        w.op = OP_CLEAR;
        return w;
    endfunction

    function automatic int unsigned pick_node_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(2, 16);
        if (roll < 85)
            return $urandom_range(17, 64);
        if (roll < 92)
            return $urandom_range(65, 1024);
        if (roll < 96)
            return $urandom_range(0, 1);
        return $urandom_range(1025, 2047);
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want, got);
        if (got !== want)
            log_failure($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    task automatic send_word(input edge_word_t w);
        edge_word  <= w;
        edge_valid <= 1'b1;
        @(posedge clk);
        while (edge_stall)
            @(posedge clk);
        expected_results.push_back(predict_result(w));
        words_sent++;
        if (w.op == OP_CLEAR)
            clears_sent++;
        if (sender_gaps && $urandom_range(0, 1))
        begin
            edge_valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
    endtask

    task automatic send_edge(input int unsigned a, b, cost, input bit fin);
        send_word(edge_of(a, b, cost, fin));
    endtask

    task automatic settle();
        edge_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [COST_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_NODE_COUNT)
            cfg_nodes = value[COUNT_W-1:0];
        else
            cfg_target = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // two nodes and target zero out of reset
    task automatic test_reset_state();
        send_edge(0, 1, 0, 0);
        send_edge(1, 0, 16'hFFFF, 0);
        send_edge(2, 0, 5, 1);
        send_word(clear_word());
        send_edge(1, 1, 7, 0);
        send_edge(1, 0, 16'hFFFF, 1);
        settle();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_NODE_COUNT, 0);
        write_register(CFG_TARGET_COST, COST_MAX);
        send_word(clear_word());
        send_edge(0, 1, 16'hFFFF, 1);
        settle();
        write_register(CFG_NODE_COUNT, 1);
        send_word(clear_word());
        send_edge(1, 0, 3, 0);
        settle();
        write_register(CFG_NODE_COUNT, 1024);
        send_word(clear_word());
        send_edge(1023, 0, 0, 0);
        send_edge(1022, 1023, 16'hFFFF, 0);
        send_edge(0, 1022, 16'hFFFF, 1);
        settle();
        write_register(CFG_NODE_COUNT, 2047);
        send_word(clear_word());
        send_edge(1023, 512, 16'hFFFF, 1);
        settle();
        // shrink without clearing: top node drops out of range
        write_register(CFG_NODE_COUNT, 1023);
        send_edge(1023, 0, 9, 0);
        send_edge(1022, 0, 9, 1);
        settle();
    endtask

    task automatic test_small_tree();
        write_register(CFG_NODE_COUNT, 4);
        write_register(CFG_TARGET_COST, 6);
        send_word(clear_word());
        send_edge(0, 1, 1, 0);
        send_edge(1, 2, 2, 0);
        send_edge(0, 2, 2, 0);
        send_edge(2, 3, 3, 0);
        send_edge(3, 0, 4, 1);
        settle();
    endtask

    task automatic run_graph_phase();
        edge_word_t graph [$];
        edge_word_t w;
        logic [$bits(edge_word_t)-1:0] raw;
        logic [63:0] rnd;
        int unsigned nodes;
        int unsigned reach;
        int unsigned cost;
        int m;
        int i;
        bit cleared;
        settle();
        nodes = pick_node_count();
        reach = (nodes < 2) ? 2 : ((nodes > MAX_NODES) ? MAX_NODES : nodes);
        write_register(CFG_NODE_COUNT, COST_W'(nodes));
        if ($urandom_range(0, 2) == 0)
            write_register(CFG_TARGET_COST, COST_W'($urandom));
        sender_gaps     = ($urandom_range(0, 3) != 0);
        receiver_stalls = sender_gaps;
        m = (reach <= 64) ? $urandom_range(reach, 3 * reach) : $urandom_range(30, 80);
        cost = ($urandom_range(0, 7) == 0) ? $urandom_range(60000, 65535)
                                           : $urandom_range(0, 200);
        for (i = 0; i < m; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                rnd = {$urandom, $urandom};
                raw = rnd[$bits(edge_word_t)-1:0];
                w = raw;
            end
            else
            begin
                w = edge_of($urandom_range(0, reach - 1), $urandom_range(0, reach - 1),
                            cost, i == m - 1);
                cost = cost + $urandom_range(0, 40);
                if (cost > 16'hFFFF)
                    cost = 16'hFFFF;
            end
            graph.push_back(w);
        end
        cleared = ($urandom_range(0, 4) != 0);
        if (cleared)
            send_word(clear_word());
        foreach (graph[k])
            send_word(graph[k]);
        settle();
        // replay a finished tree with its own cost as target
        if (cleared && tree_edges == reach - 1 && $urandom_range(0, 1))
        begin
            write_register(CFG_TARGET_COST, COST_W'(tree_cost));
            send_word(clear_word());
            foreach (graph[k])
                send_word(graph[k]);
        end
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_random_graphs();
        int unsigned stop_at;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at)
            run_graph_phase();
        settle();
    endtask

    // receiver holds off while words keep coming, so the core backs up
    task automatic test_backpressure();
        int i;
        write_register(CFG_NODE_COUNT, 48);
        sender_gaps = 1'b0;
        hold_cycles = 400;
        send_word(clear_word());
        for (i = 0; i < 40; i++)
            send_edge($urandom_range(0, 47), $urandom_range(0, 47), 100 + i, i == 39);
        sender_gaps = 1'b1;
        settle();
    endtask

    initial
    begin : result_receiver
        forever
        begin
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!receiver_stalls || $urandom_range(0, 2) != 0)
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b1;
                repeat (gap_length()) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_checker
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                log_failure($sformatf("unexpected result word %h", result_word));
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("taken", want.taken, result_word.taken);
                compare_field("total_cost", want.total_cost, result_word.total_cost);
                compare_field("used_edges", want.used_edges, result_word.used_edges);
                compare_field("tree_complete", want.tree_complete, result_word.tree_complete);
                compare_field("cost_matches", want.cost_matches, result_word.cost_matches);
                compare_field("last_flag", want.last_flag, result_word.last_flag);
                if (want.taken)
                    taken_seen++;
                if (want.cost_matches)
                    matches_seen++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((edge_valid && !edge_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("kruskal_edge_acceptor_core_test failed");
        $finish;
    end

    initial
    begin : run_tests
        rst_n      <= 1'b0;
        edge_valid <= 1'b0;
        edge_word  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_NODE_COUNT;
        cfg_data   <= '0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_cycles     = 0;
        cfg_nodes  = MIN_NODES;
        cfg_target = '0;
        clear_forest();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_extremes();
        test_small_tree();
        test_backpressure();
        test_random_graphs();
        settle();

        $display("Ran %0d words (%0d clears) through the edge acceptor, checked %0d results:",
                 words_sent, clears_sent, results_seen);
        $display("%0d edges taken, %0d cost matches, %0d mismatches",
                 taken_seen, matches_seen, mismatches);
        if (mismatches == 0)
            $display("kruskal_edge_acceptor_core_test passed");
        else
            $display("kruskal_edge_acceptor_core_test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/kea_pkg.sv
rtl/kea_ram.sv
rtl/kea_forest_seq.sv
rtl/kruskal_edge_acceptor_core.sv
sim/kruskal_edge_acceptor_core_test.sv
